/* sv/sm4_pkg.sv */
// SM4 round engine package: command codes, sizes, control struct and the
// S-box / linear transform used by the round datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned KEY_DEPTH = 32;
  localparam int unsigned KEY_AW    = $clog2(KEY_DEPTH);

  // Item commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ENC  = 2'd1,
    CMD_DEC  = 2'd2
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_blk;   // capture input block into the round state
    logic do_round;   // run one round with the key word from the store
    logic push_out;   // copy final state into the output register
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution
  function automatic logic [WORD_W-1:0] tau_f(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] b;
    b = '0;
    for (int k = 0; k < 4; k++) begin
      b[8*k +: 8] = SBOX[a[8*k +: 8]];
    end
    return b;
  endfunction

  // Linear diffusion: b ^ rotl 2 ^ rotl 10 ^ rotl 18 ^ rotl 24
  function automatic logic [WORD_W-1:0] lin_f(input logic [WORD_W-1:0] b);
    return b ^ {b[WORD_W-3:0],  b[WORD_W-1 -: 2]}
             ^ {b[WORD_W-11:0], b[WORD_W-1 -: 10]}
             ^ {b[WORD_W-19:0], b[WORD_W-1 -: 18]}
             ^ {b[WORD_W-25:0], b[WORD_W-1 -: 24]};
  endfunction

endpackage

`default_nettype wire

/* sv/sm4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sm4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/sm4_ctrl.sv */
// SM4 round engine controller: handshakes, round counter, key store
// addressing and output-valid flag. Depends on sm4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm4_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  cmd_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             key_we_o,
  output logic      [sm4_pkg::KEY_AW-1:0]  key_raddr_o,
  output sm4_pkg::dp_cmd_t                 dp_cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ROUND,
    ST_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [sm4_pkg::KEY_AW-1:0] rnd_q, rnd_d;
  logic                       dec_q, dec_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       start;
  logic                       push;
  logic [sm4_pkg::KEY_AW-1:0] key_idx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (cmd_i == sm4_pkg::CMD_ENC || cmd_i == sm4_pkg::CMD_DEC);
  assign key_we_o   = accept && (cmd_i == sm4_pkg::CMD_LOAD);
  assign push       = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Key for the round after the current one; decrypt walks the store backward
  assign key_idx     = (state_q == ST_ROUND) ? rnd_q + 1'b1 : rnd_q;
  assign key_raddr_o = dec_q ? ~key_idx : key_idx;

  assign dp_cmd_o.load_blk = start;
  assign dp_cmd_o.do_round = (state_q == ST_ROUND);
  assign dp_cmd_o.push_out = push;
  assign out_valid_o       = out_valid_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    dec_d       = dec_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_FETCH;
          rnd_d   = '0;
          dec_d   = (cmd_i == sm4_pkg::CMD_DEC);
        end
      end
      ST_FETCH: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == sm4_pkg::KEY_AW'(sm4_pkg::ROUNDS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (push) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* sv/sm4_dpath.sv */
// SM4 round engine datapath: four-word round state, shared round function
// and result register. Depends on sm4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm4_dpath (
  input  wire logic                        clk_i,
  input  wire sm4_pkg::dp_cmd_t            dp_cmd_i,
  input  wire logic [sm4_pkg::WORD_W-1:0]  rk_i,
  input  wire logic [sm4_pkg::WORD_W-1:0]  in_word0_i,
  input  wire logic [sm4_pkg::WORD_W-1:0]  in_word1_i,
  input  wire logic [sm4_pkg::WORD_W-1:0]  in_word2_i,
  input  wire logic [sm4_pkg::WORD_W-1:0]  in_word3_i,
  output logic      [sm4_pkg::WORD_W-1:0]  out_word0_o,
  output logic      [sm4_pkg::WORD_W-1:0]  out_word1_o,
  output logic      [sm4_pkg::WORD_W-1:0]  out_word2_o,
  output logic      [sm4_pkg::WORD_W-1:0]  out_word3_o
);

  logic [sm4_pkg::WORD_W-1:0] x_q [4];
  logic [sm4_pkg::WORD_W-1:0] y_q [4];
  logic [sm4_pkg::WORD_W-1:0] new_word;

  // One round: X0 ^ L(tau(X1 ^ X2 ^ X3 ^ rk))
  assign new_word = x_q[0] ^ sm4_pkg::lin_f(sm4_pkg::tau_f(x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_i));

  // Round state shift register
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_blk) begin
      x_q[0] <= in_word0_i;
      x_q[1] <= in_word1_i;
      x_q[2] <= in_word2_i;
      x_q[3] <= in_word3_i;
    end else if (dp_cmd_i.do_round) begin
      x_q[0] <= x_q[1];
      x_q[1] <= x_q[2];
      x_q[2] <= x_q[3];
      x_q[3] <= new_word;
    end
  end

  // Result register, words in reversed order
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.push_out) begin
      y_q[0] <= x_q[3];
      y_q[1] <= x_q[2];
      y_q[2] <= x_q[1];
      y_q[3] <= x_q[0];
    end
  end

  assign out_word0_o = y_q[0];
  assign out_word1_o = y_q[1];
  assign out_word2_o = y_q[2];
  assign out_word3_o = y_q[3];

endmodule

`default_nettype wire

/* sv/sm4_block_round_engine_unit.sv */
// SM4 round engine. A load beat leaves the input side open. A cipher beat runs
// from acceptance to result valid through one key-store read, 32 rounds through the
// single shared round function (one per cycle) and the output register.
// The input reopens as the result is registered, which waits while an earlier
// result still sits unread in the output register.
// Reset clears control only; the round-key store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sm4_block_round_engine_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [4:0]                  key_index_i,
  input  wire logic [31:0]                 key_word_i,
  input  wire logic [31:0]                 in_word0_i,
  input  wire logic [31:0]                 in_word1_i,
  input  wire logic [31:0]                 in_word2_i,
  input  wire logic [31:0]                 in_word3_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [31:0]                 out_word0_o,
  output logic      [31:0]                 out_word1_o,
  output logic      [31:0]                 out_word2_o,
  output logic      [31:0]                 out_word3_o
);

  sm4_pkg::dp_cmd_t           dp_cmd;
  logic                       key_we;
  logic [sm4_pkg::KEY_AW-1:0] key_raddr;
  logic [sm4_pkg::WORD_W-1:0] rk;

  sm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_we_o    (key_we),
    .key_raddr_o (key_raddr),
    .dp_cmd_o    (dp_cmd)
  );

  // Round-key store
  sm4_ram #(
    .WIDTH (32),
    .DEPTH (32)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_index_i),
    .wdata_i (key_word_i),
    .raddr_i (key_raddr),
    .rdata_o (rk)
  );

  sm4_dpath u_dpath (
    .clk_i       (clk_i),
    .dp_cmd_i    (dp_cmd),
    .rk_i        (rk),
    .in_word0_i  (in_word0_i),
    .in_word1_i  (in_word1_i),
    .in_word2_i  (in_word2_i),
    .in_word3_i  (in_word3_i),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o),
    .out_word2_o (out_word2_o),
    .out_word3_o (out_word3_o)
  );

  // A cipher beat keeps the input side closed for the whole round sequence
  a_busy_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_blk |=> !in_ready_o ##33 !in_ready_o)
    else $error("input reopened before rounds finished");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.push_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while full");

  // Datapath commands are mutually exclusive
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.load_blk, dp_cmd.do_round, dp_cmd.push_out}))
    else $error("conflicting datapath commands");

  // Key writes only happen while idle, never during rounds
  a_key_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> !dp_cmd.do_round && in_ready_o)
    else $error("key store written during cipher");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for sm4_block_round_engine_unit: round-key loads, encrypt and
// decrypt beats, ignored commands, random traffic with stalls on both channels.
// Depends on sm4_pkg (sv/sm4_pkg.sv) and the engine RTL; nothing else.
`timescale 1ns / 1ps

module testbench;

  // Unused command code, must be dropped by the engine
  localparam logic [1:0]  CMD_NOP        = 2'd3;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL     = 40;
  localparam int unsigned RANDOM_ITEMS   = 820;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } block_t;

  // Standard SM4 byte substitution table
  localparam logic [7:0] BYTE_SUB_LUT [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [4:0]  key_index;
  logic [31:0] key_word;
  logic [31:0] in_word0, in_word1, in_word2, in_word3;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_word0, out_word1, out_word2, out_word3;

  // Shadow of the round-key store and the ciphered blocks still in flight
  logic [31:0] key_store [32];
  block_t      pending_cipher_out [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          no_idle        = 1'b0;
  bit          rx_hold_req    = 1'b0;

  sm4_block_round_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .key_index_i (key_index),
    .key_word_i  (key_word),
    .in_word0_i  (in_word0),
    .in_word1_i  (in_word1),
    .in_word2_i  (in_word2),
    .in_word3_i  (in_word3),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word0_o (out_word0),
    .out_word1_o (out_word1),
    .out_word2_o (out_word2),
    .out_word3_o (out_word3)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte substitution followed by the linear diffusion
  function automatic logic [31:0] round_mix(input logic [31:0] a);
    logic [31:0] b;
    int          k;
    for (k = 0; k < 4; k++) begin
      b[8*k +: 8] = BYTE_SUB_LUT[a[8*k +: 8]];
    end
    return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
  endfunction

  // 32 rounds with the shadow keys; decrypt walks the keys backwards
  function automatic block_t cipher_block(input logic [1:0] op, input block_t blk);
    logic [31:0] x [4];
    logic [31:0] rk;
    logic [31:0] nw;
    block_t      res;
    int          r;
    x[0] = blk.w0;
    x[1] = blk.w1;
    x[2] = blk.w2;
    x[3] = blk.w3;
    for (r = 0; r < sm4_pkg::ROUNDS; r++) begin
      rk   = key_store[5'((op == sm4_pkg::CMD_ENC) ? r : (sm4_pkg::ROUNDS - 1 - r))];
      nw   = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nw;
    end
    res.w0 = x[3];
    res.w1 = x[2];
    res.w2 = x[1];
    res.w3 = x[0];
    return res;
  endfunction

  // Words biased toward the extremes
  function automatic logic [31:0] rand_word();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hffff_ffff;
    if (sel == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic block_t rand_block();
    block_t blk;
    blk.w0 = rand_word();
    blk.w1 = rand_word();
    blk.w2 = rand_word();
    blk.w3 = rand_word();
    return blk;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Input beats update the key shadow or queue a predicted block
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      case (cmd) inside
        sm4_pkg::CMD_LOAD: begin
          key_store[key_index] = key_word;
        end
        sm4_pkg::CMD_ENC, sm4_pkg::CMD_DEC: begin
          pending_cipher_out.push_back(
            cipher_block(cmd, {in_word0, in_word1, in_word2, in_word3}));
        end
        default: begin
        end
      endcase
    end
  end

  // Output beats compared word by word against the oldest prediction
  always @(posedge clk_i) begin
    block_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_cipher_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h %h %h",
                                  out_word0, out_word1, out_word2, out_word3));
      end else begin
        want = pending_cipher_out.pop_front();
        if (out_word0 !== want.w0)
          report_mismatch($sformatf("out_word0 got %h want %h", out_word0, want.w0));
        if (out_word1 !== want.w1)
          report_mismatch($sformatf("out_word1 got %h want %h", out_word1, want.w1));
        if (out_word2 !== want.w2)
          report_mismatch($sformatf("out_word2 got %h want %h", out_word2, want.w2));
        if (out_word3 !== want.w3)
          report_mismatch($sformatf("out_word3 got %h want %h", out_word3, want.w3));
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sm4_block_round_engine_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side pacing: random stall per beat, optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Returns at the accepting edge with valid still high; the next call or
  // drain_results decides whether it drops.
  task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                           input logic [31:0] kw, input block_t blk);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    key_index <= idx;
    key_word  <= kw;
    in_word0  <= blk.w0;
    in_word1  <= blk.w1;
    in_word2  <= blk.w2;
    in_word3  <= blk.w3;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic load_key(input logic [4:0] idx, input logic [31:0] kw);
    send_item(sm4_pkg::CMD_LOAD, idx, kw, rand_block());
  endtask

  task automatic cipher(input logic [1:0] op, input block_t blk);
    send_item(op, 5'($urandom), $urandom, blk);
  endtask

  // Sender goes quiet until every predicted block has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cipher_out.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fill every key slot, extremes in the first and last slots
  task automatic test_key_load();
    logic [31:0] kw;
    int          k;
    for (k = 0; k < 32; k++) begin
      case (k)
        0:       kw = 32'h0000_0000;
        1:       kw = 32'h8000_0000;
        2:       kw = 32'h0000_0001;
        31:      kw = 32'hffff_ffff;
        default: kw = $urandom;
      endcase
      load_key(k[4:0], kw);
    end
  endtask

  // Extreme blocks in both directions, a round trip and a key overwrite
  task automatic test_directed_blocks();
    block_t pt;
    block_t blocks [6];
    int     i;
    blocks[0] = '0;
    blocks[1] = '1;
    blocks[2] = {32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};
    blocks[3] = {4{32'h5555_aaaa}};
    blocks[4] = {32'h8000_0000, 96'h0};
    blocks[5] = {96'h0, 32'h0000_0001};
    for (i = 0; i < 6; i++) begin
      cipher(sm4_pkg::CMD_ENC, blocks[i]);
      cipher(sm4_pkg::CMD_DEC, blocks[i]);
    end
    pt = blocks[2];
    cipher(sm4_pkg::CMD_ENC, pt);
    cipher(sm4_pkg::CMD_DEC, cipher_block(sm4_pkg::CMD_ENC, pt));
    load_key(5'd31, 32'h0000_0000);
    cipher(sm4_pkg::CMD_ENC, blocks[2]);
    load_key(5'd31, 32'hffff_ffff);
  endtask

  // Unused command must neither write a key nor produce a result
  task automatic test_ignored_command();
    send_item(CMD_NOP, 5'd0, 32'hdead_beef, '1);
    cipher(sm4_pkg::CMD_ENC, '0);
    send_item(CMD_NOP, 5'd31, 32'h0000_0000, rand_block());
    send_item(CMD_NOP, 5'($urandom), $urandom, rand_block());
    cipher(sm4_pkg::CMD_DEC, '1);
  endtask

  // Result side holds off while the sender keeps offering beats
  task automatic test_backpressure();
    int i;
    no_idle     = 1'b1;
    rx_hold_req = 1'b1;
    for (i = 0; i < 6; i++) begin
      cipher(($urandom_range(0, 1) != 0) ? sm4_pkg::CMD_ENC : sm4_pkg::CMD_DEC,
             rand_block());
    end
    no_idle = 1'b0;
  endtask

  // Mostly ciphers on random data, some key rewrites, round trips and noise
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    block_t      pt;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 100 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (sent % 150 == 149) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_key(5'($urandom), rand_word());
        sent++;
      end else if (pick < 12) begin
        send_item(CMD_NOP, 5'($urandom), $urandom, rand_block());
      end else if (pick < 20) begin
        pt = rand_block();
        cipher(sm4_pkg::CMD_ENC, pt);
        cipher(sm4_pkg::CMD_DEC, cipher_block(sm4_pkg::CMD_ENC, pt));
        sent += 2;
      end else begin
        cipher(($urandom_range(0, 1) != 0) ? sm4_pkg::CMD_ENC : sm4_pkg::CMD_DEC,
               rand_block());
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    cmd       = CMD_NOP;
    key_index = '0;
    key_word  = '0;
    in_word0  = '0;
    in_word1  = '0;
    in_word2  = '0;
    in_word3  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_key_load();
    test_directed_blocks();
    drain_results();
    test_ignored_command();
    drain_results();
    test_backpressure();
    drain_results();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();

    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0 && pending_cipher_out.size() == 0) begin
      $display("sm4_block_round_engine_unit test passed");
    end else begin
      $display("sm4_block_round_engine_unit test failed");
    end
    $finish;
  end

endmodule
